### src/pfps_pkg.sv
`default_nettype none
package pfps_pkg;

  // Scan phase, one-hot
  typedef enum logic [3:0] {
    PH_TAG  = 4'b0001,
    PH_VAL  = 4'b0010,
    PH_LEN  = 4'b0100,
    PH_SKIP = 4'b1000
  } phase_t;

  localparam logic [1:0] DEC_NONE   = 2'd0;
  localparam logic [1:0] DEC_FOUND  = 2'd1;
  localparam logic [1:0] DEC_REJECT = 2'd2;

  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN     = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  localparam logic REG_MATCH_FIRST  = 1'b0;
  localparam logic REG_MATCH_SECOND = 1'b1;

  localparam logic [31:0] MATCH_FIRST_RESET  = 32'd12;
  localparam logic [31:0] MATCH_SECOND_RESET = 32'd13;

  localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;
  localparam int FIXED64_BYTES = 8;
  localparam int FIXED32_BYTES = 4;

  localparam int SKIP_COUNT_BITS_DEFAULT = 32;

endpackage
`default_nettype wire

### src/protobuf_field_presence_scanner.sv
`default_nettype none
// The verdict is registered and shows in the cycle after the last byte's transfer.
// Throughput: one byte per cycle while the input is not stalled; each byte is a single
// pass through the tag/length decode between the scan state registers and the verdict register.
// Input is stalled only while a verdict waits and the output is not ready.
// Reset (rst, synchronous): scan state cleared, no verdict pending, match fields 12 and 13.
module protobuf_field_presence_scanner #(
  parameter int SKIP_COUNT_BITS = pfps_pkg::SKIP_COUNT_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       verdict,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  pfps_pkg::phase_t            phase, phase_next;
  logic [63:0]                 acc, acc_next;
  logic [3:0]                  cnt, cnt_next;
  logic [SKIP_COUNT_BITS-1:0]  skip, skip_next;
  logic [1:0]                  decision, decision_next;
  logic [1:0]                  verdict_next;
  logic [31:0]                 match_first, match_second;

  logic                        in_fire;
  logic [63:0]                 acc_or;
  logic [6:0]                  shamt;
  logic [3:0]                  cnt_inc;
  logic [SKIP_COUNT_BITS-1:0]  skip_dec;
  logic [31:0]                 fld;
  logic [2:0]                  wt;
  logic                        len_over;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign shamt    = 7'(cnt) * 7'd7;
  assign acc_or   = (cnt < pfps_pkg::VARINT_MAX_BYTES) ?
                    (acc | ({56'd0, 1'b0, data_byte[6:0]} << shamt)) : acc;
  assign cnt_inc  = cnt + 4'd1;
  assign fld      = acc_or[34:3];
  assign wt       = acc_or[2:0];
  // Length too big for the skip counter
  assign len_over = |(acc_or >> SKIP_COUNT_BITS);
  assign skip_dec = (skip != '0) ? skip - SKIP_COUNT_BITS'(1) : skip;

  always_comb begin
    phase_next    = phase;
    acc_next      = acc;
    cnt_next      = cnt;
    skip_next     = skip;
    decision_next = decision;
    verdict_next  = pfps_pkg::DEC_NONE;

    if (decision == pfps_pkg::DEC_NONE) begin
      if (phase == pfps_pkg::PH_SKIP) begin
        skip_next = skip_dec;
        if (skip_dec == '0) begin
          phase_next = pfps_pkg::PH_TAG;
        end
      end else if (data_byte[7]) begin
        acc_next = acc_or;
        cnt_next = cnt_inc;
        if (cnt_inc >= pfps_pkg::VARINT_MAX_BYTES) begin
          decision_next = pfps_pkg::DEC_REJECT;
        end
      end else begin
        acc_next = '0;
        cnt_next = '0;
        case (phase)
          pfps_pkg::PH_TAG: begin
            if (fld == '0) begin
              decision_next = pfps_pkg::DEC_REJECT;
            end else begin
              case (wt)
                pfps_pkg::WT_VARINT: begin
                  phase_next = pfps_pkg::PH_VAL;
                end
                pfps_pkg::WT_FIXED64: begin
                  skip_next  = SKIP_COUNT_BITS'(pfps_pkg::FIXED64_BYTES);
                  phase_next = pfps_pkg::PH_SKIP;
                end
                pfps_pkg::WT_LEN: begin
                  if (fld == match_first || fld == match_second) begin
                    decision_next = pfps_pkg::DEC_FOUND;
                  end else begin
                    phase_next = pfps_pkg::PH_LEN;
                  end
                end
                pfps_pkg::WT_FIXED32: begin
                  skip_next  = SKIP_COUNT_BITS'(pfps_pkg::FIXED32_BYTES);
                  phase_next = pfps_pkg::PH_SKIP;
                end
                default: begin
                  decision_next = pfps_pkg::DEC_REJECT;
                end
              endcase
            end
          end
          pfps_pkg::PH_VAL: begin
            phase_next = pfps_pkg::PH_TAG;
          end
          default: begin
            if (len_over) begin
              decision_next = pfps_pkg::DEC_REJECT;
            end else if (acc_or == '0) begin
              phase_next = pfps_pkg::PH_TAG;
            end else begin
              skip_next  = acc_or[SKIP_COUNT_BITS-1:0];
              phase_next = pfps_pkg::PH_SKIP;
            end
          end
        endcase
      end
    end

    if (last_byte) begin
      if (decision_next != pfps_pkg::DEC_NONE) begin
        verdict_next = decision_next;
      end else if (phase_next == pfps_pkg::PH_TAG && cnt_next == '0) begin
        verdict_next = pfps_pkg::DEC_NONE;
      end else begin
        verdict_next = pfps_pkg::DEC_REJECT;
      end
      // next message starts clean
      phase_next    = pfps_pkg::PH_TAG;
      acc_next      = '0;
      cnt_next      = '0;
      skip_next     = '0;
      decision_next = pfps_pkg::DEC_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= pfps_pkg::PH_TAG;
      acc      <= '0;
      cnt      <= '0;
      skip     <= '0;
      decision <= pfps_pkg::DEC_NONE;
    end else if (in_fire) begin
      phase    <= phase_next;
      acc      <= acc_next;
      cnt      <= cnt_next;
      skip     <= skip_next;
      decision <= decision_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && last_byte) begin
      verdict <= verdict_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_first  <= pfps_pkg::MATCH_FIRST_RESET;
      match_second <= pfps_pkg::MATCH_SECOND_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pfps_pkg::REG_MATCH_FIRST:  match_first  <= cfg_data;
        pfps_pkg::REG_MATCH_SECOND: match_second <= cfg_data;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= pfps_pkg::VARINT_MAX_BYTES)
    else $error("varint byte count past limit");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == pfps_pkg::PH_SKIP |-> skip != '0)
    else $error("skip phase with empty count");

  a_last_gives_verdict: assert property (@(posedge clk) disable iff (rst)
    in_fire && last_byte |=> out_valid && verdict != 2'd3)
    else $error("no legal verdict after last byte transfer");

  a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without pending verdict");
`endif

endmodule
`default_nettype wire
